FILE: rtl/mske_pkg.sv
package mske_pkg;

    localparam int SEED_W      = 16;
    localparam int WORD_W      = 32;
    localparam int HALF_W      = 16;
    localparam int EXP_BITS    = 13;
    localparam int QUO_SHIFT   = 13;
    localparam int QUO_W       = WORD_W - QUO_SHIFT;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [EXP_BITS-1:0] EXPONENT = 13'h12e5;
    localparam logic [WORD_W-1:0]   RECIP    = 32'h82b87f05;
    localparam logic [13:0]         MODULUS  = 14'h3eab;

    typedef logic [SEED_W-1:0] seed_t;
    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic  valid;
        seed_t seed;
    } seed_xfer_t;

endpackage

FILE: rtl/mske_front.sv
module mske_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 seed_valid,
    output logic                 seed_stall,
    input  mske_pkg::seed_t      seed,
    input  logic                 q_full,
    output mske_pkg::seed_xfer_t push
);
    import mske_pkg::*;

    logic  valid_reg;
    seed_t seed_reg;

    assign seed_stall = valid_reg && q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!seed_stall)
        begin
            valid_reg <= seed_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!seed_stall)
        begin
            seed_reg <= seed;
        end
    end

    assign push.valid = valid_reg && !q_full;
    assign push.seed  = seed_reg;

endmodule

FILE: rtl/mske_queue.sv
module mske_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mske_pkg::seed_xfer_t push,
    output logic                 full,
    input  logic                 pop_en,
    output mske_pkg::seed_xfer_t head
);
    import mske_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    seed_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             wr;
    logic             rd;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.seed  = mem_reg[rd_ptr_reg];
    assign wr         = push.valid;
    assign rd         = head.valid && pop_en;

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({wr, rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= push.seed;
        end
    end

endmodule

FILE: rtl/mske_back.sv
module mske_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mske_pkg::seed_xfer_t head,
    output logic                 pop_en,
    output logic                 key_valid,
    input  logic                 key_stall,
    output mske_pkg::word_t      key
);
    import mske_pkg::*;

    localparam word_t MIX_XOR_LO  = 32'h0000000f;
    localparam word_t MIX_XOR_KEY = 32'had0779e2;
    localparam word_t BYTE0_MASK  = 32'h000000ff;
    localparam word_t BYTE1_MASK  = 32'h0000ff00;

    function automatic word_t mix_key(input word_t r);
        word_t t5;
        word_t t6;
        word_t t7;
        t5 = ((r >> 8) + r) ^ MIX_XOR_LO;
        t6 = (r ^ (t5 << 8)) & BYTE1_MASK;
        t7 = ((r ^ t5) & BYTE0_MASK) | t6;
        return (t7 | (t7 << 16)) ^ MIX_XOR_KEY;
    endfunction

    logic  en;
    logic  v0_reg;
    word_t acc0_reg;
    word_t base0_reg;
    logic  out_valid_reg;
    word_t key_reg;

    logic  vld_in  [EXP_BITS+1];
    word_t acc_in  [EXP_BITS+1];
    word_t base_in [EXP_BITS+1];

    assign en     = !(out_valid_reg && key_stall);
    assign pop_en = en;

    assign vld_in[0]  = v0_reg;
    assign acc_in[0]  = acc0_reg;
    assign base_in[0] = base0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= head.valid;
            out_valid_reg <= vld_in[EXP_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc0_reg  <= word_t'(1);
            base0_reg <= word_t'(head.seed);
            key_reg   <= mix_key(acc_in[EXP_BITS]);
        end
    end

    for (genvar k = 0; k < EXP_BITS; k++)
    begin : g_round
        localparam bit MulOn = EXPONENT[k];

        logic              v1_reg;
        logic              v2_reg;
        logic              v3_reg;
        logic              v4_reg;
        word_t             prod   [2];
        word_t             low    [2];
        word_t             mid    [2];
        word_t             top    [2];
        word_t             red    [2];
        word_t             p1_reg [2];
        word_t             p2_reg [2];
        word_t             ll_reg [2];
        word_t             lh_reg [2];
        word_t             hl_reg [2];
        word_t             hh_reg [2];
        word_t             p3_reg [2];
        logic [QUO_W-1:0]  q3_reg [2];
        word_t             r4_reg [2];

        always_comb
        begin
            prod[0] = MulOn ? word_t'(acc_in[k] * base_in[k]) : acc_in[k];
            prod[1] = word_t'(base_in[k] * base_in[k]);
            for (int j = 0; j < 2; j++)
            begin
                low[j] = ll_reg[j] >> HALF_W;
                mid[j] = low[j] + lh_reg[j] + hl_reg[j];
                top[j] = (mid[j] >> HALF_W) + hh_reg[j];
                red[j] = p3_reg[j] - word_t'(word_t'(q3_reg[j]) * word_t'(MODULUS));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v1_reg <= 1'b0;
                v2_reg <= 1'b0;
                v3_reg <= 1'b0;
                v4_reg <= 1'b0;
            end
            else if (en)
            begin
                v1_reg <= vld_in[k];
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    p1_reg[j] <= prod[j];
                    p2_reg[j] <= p1_reg[j];
                    ll_reg[j] <= word_t'(p1_reg[j][HALF_W-1:0]) * word_t'(RECIP[HALF_W-1:0]);
                    lh_reg[j] <= word_t'(p1_reg[j][HALF_W-1:0])
                                 * word_t'(RECIP[WORD_W-1:HALF_W]);
                    hl_reg[j] <= word_t'(RECIP[HALF_W-1:0])
                                 * word_t'(p1_reg[j][WORD_W-1:HALF_W]);
                    hh_reg[j] <= word_t'(p1_reg[j][WORD_W-1:HALF_W])
                                 * word_t'(RECIP[WORD_W-1:HALF_W]);
                    p3_reg[j] <= p2_reg[j];
                    q3_reg[j] <= top[j][WORD_W-1:QUO_SHIFT];
                end
                r4_reg[0] <= MulOn ? red[0] : p3_reg[0];
                r4_reg[1] <= red[1];
            end
        end

        assign vld_in[k+1]  = v4_reg;
        assign acc_in[k+1]  = r4_reg[0];
        assign base_in[k+1] = r4_reg[1];
    end

    assign key_valid = out_valid_reg;
    assign key       = key_reg;

`ifndef SYNTH
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v0_reg) && $stable(vld_in[EXP_BITS]))
        else $error("pipeline advanced while output was stalled");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(vld_in[EXP_BITS]))
        else $error("result appeared without a finished transaction");

    a_entry_load: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> v0_reg == $past(head.valid))
        else $error("queue head not taken into pipeline");
`endif

endmodule

FILE: rtl/modexp_seed_key.sv
// Path: the front register loads a seed at the accepting edge, then it passes the queue,
// the entry register, 13 rounds of 4 stages and the key register that drives key valid.
// Throughput: one seed per cycle unless key_stall holds the key; each round stage holds at
// most one 32x32 or four 16x16 multipliers per product; the whole pipeline advances together.
// Reset: rst_n clears all valid and queue state asynchronously; data is not reset.
module modexp_seed_key (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            seed_valid,
    output logic            seed_stall,
    input  mske_pkg::seed_t seed,
    output logic            key_valid,
    input  logic            key_stall,
    output mske_pkg::word_t key
);
    import mske_pkg::*;

    seed_xfer_t push;
    seed_xfer_t head;
    logic       q_full;
    logic       pop_en;

    mske_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_valid (seed_valid),
        .seed_stall (seed_stall),
        .seed       (seed),
        .q_full     (q_full),
        .push       (push)
    );

    mske_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (q_full),
        .pop_en (pop_en),
        .head   (head)
    );

    mske_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop_en    (pop_en),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .key       (key)
    );

endmodule

FILE: test/tb_modexp_seed_key.sv
`timescale 1ns / 100ps

module tb_modexp_seed_key;

    import mske_pkg::*;

    localparam word_t BARRETT_MOD = 32'h00003eab;
    localparam word_t MIX_LO_XOR  = 32'h0000000f;
    localparam word_t MIX_KEY_XOR = 32'had0779e2;
    localparam word_t LOW_HALF    = 32'h0000ffff;
    localparam word_t BYTE1_BITS  = 32'h0000ff00;
    localparam word_t BYTE0_BITS  = 32'h000000ff;
    localparam int    QUOT_SHIFT  = 13;
    localparam int    DRAIN_WAIT  = 80;
    localparam int    SHOW_LIMIT  = 10;
    localparam int    RAND_SEEDS  = 1400;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  seed_valid = 1'b0;
    logic  seed_stall;
    seed_t seed = '0;
    logic  key_valid;
    logic  key_stall = 1'b0;
    word_t key;

    seed_t pending_seeds[$];
    word_t expected_keys[$];

    int send_idle_pct = 16;
    int recv_stall_pct = 50;
    int fail_count = 0;
    int mismatch_count = 0;

    modexp_seed_key uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_valid (seed_valid),
        .seed_stall (seed_stall),
        .seed       (seed),
        .key_valid  (key_valid),
        .key_stall  (key_stall),
        .key        (key)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Barrett step: quotient from a split 16x16 product, all wrapping at 32 bits.
    function automatic word_t barrett_reduce(word_t p);
        word_t pl, ph, rl, rh, lo_part, mid_part, top_part, quot, prod;
        begin
            pl = p & LOW_HALF;
            ph = p >> 16;
            rl = RECIP & LOW_HALF;
            rh = RECIP >> 16;
            prod = pl * rl;
            lo_part = prod >> 16;
            mid_part = lo_part + pl * rh + rl * ph;
            top_part = (mid_part >> 16) + ph * rh;
            quot = top_part >> QUOT_SHIFT;
            prod = quot * BARRETT_MOD;
            barrett_reduce = p - prod;
        end
    endfunction

    function automatic word_t seed_to_key(seed_t s);
        word_t base, power, prod, t5, t6, t7, mixed;
        logic [EXP_BITS-1:0] exp_bits;
        int k;
        begin
            base = {16'h0000, s};
            power = 32'd1;
            exp_bits = EXPONENT;
            for (k = 0; k < EXP_BITS; k++)
            begin
                if (exp_bits[0])
                begin
                    prod = power * base;
                    power = barrett_reduce(prod);
                end
                prod = base * base;
                base = barrett_reduce(prod);
                exp_bits = exp_bits >> 1;
            end
            t5 = ((power >> 8) + power) ^ MIX_LO_XOR;
            t6 = (power ^ (t5 << 8)) & BYTE1_BITS;
            t7 = ((power ^ t5) & BYTE0_BITS) | t6;
            mixed = (t7 | (t7 << 16)) ^ MIX_KEY_XOR;
            seed_to_key = mixed;
        end
    endfunction

    // Record accepted seeds, then hold or advance the offered transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_valid <= 1'b0;
        end
        else
        begin
            if (seed_valid && !seed_stall)
                expected_keys.push_back(seed_to_key(seed));
            if (!seed_valid || !seed_stall)
            begin
                if (pending_seeds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    seed_valid <= 1'b1;
                    seed <= pending_seeds.pop_front();
                end
                else
                begin
                    seed_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_stall <= 1'b0;
        end
        else
        begin
            if (key_valid && !key_stall)
            begin
                if (expected_keys.size() == 0)
                begin
                    fail_count++;
                    $display("unexpected key transaction: %h", key);
                end
                else if (key !== expected_keys[0])
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT)
                        $display("key mismatch: expected %h actual %h",
                                 expected_keys[0], key);
                    void'(expected_keys.pop_front());
                end
                else
                begin
                    void'(expected_keys.pop_front());
                end
            end
            key_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        #2400000;
        $display("[modexp_seed_key] ERROR");
        $finish;
    end

    initial
    begin
        int phase;
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pending_seeds.push_back(16'h0000);
        pending_seeds.push_back(16'h0001);
        pending_seeds.push_back(16'h0002);
        pending_seeds.push_back(16'hffff);
        pending_seeds.push_back(16'hfffe);
        pending_seeds.push_back(16'h8000);
        pending_seeds.push_back(16'h7fff);
        pending_seeds.push_back(16'h00ff);
        pending_seeds.push_back(16'hff00);
        pending_seeds.push_back(16'h5555);
        pending_seeds.push_back(16'haaaa);
        pending_seeds.push_back(16'h3eab);
        pending_seeds.push_back(16'h3eaa);
        pending_seeds.push_back(16'h3eac);
        pending_seeds.push_back(16'h7d56);
        pending_seeds.push_back(16'hfaac);
        pending_seeds.push_back(16'h0100);
        pending_seeds.push_back(16'h1000);

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 16; recv_stall_pct = 50; end
                1: begin send_idle_pct = 50; recv_stall_pct = 16; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (n = 0; n < RAND_SEEDS / 3; n++)
                pending_seeds.push_back(seed_t'($urandom_range(0, 65535)));
            while (pending_seeds.size() != 0 || seed_valid)
                @(posedge clk);
        end

        while (expected_keys.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0 && expected_keys.size() == 0)
            $display("[modexp_seed_key] OK");
        else
            $display("[modexp_seed_key] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mske_pkg.sv
rtl/mske_front.sv
rtl/mske_queue.sv
rtl/mske_back.sv
rtl/modexp_seed_key.sv
test/tb_modexp_seed_key.sv
